FILE: hdl/oerq_pkg.sv
// Shared types and constants of the overwriting event ring queue.
package oerq_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int LAP_W_DEF     = 32;

  // ring size register
  localparam int               CFG_W         = 11;
  localparam logic [CFG_W-1:0] RING_SIZE_RST = 11'd1024;

  // per-item status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  // input function codes
  typedef enum logic {
    FUNC_POST = 1'b0,
    FUNC_GET  = 1'b1
  } func_t;

  // sequencer states
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_READ = 1'b1
  } seq_state_t;

  // one event record as held in a slot
  typedef struct packed {
    logic [16:0] attributes;
    logic [15:0] portal_index;
    logic [63:0] user_job_ids;
    logic [63:0] peer_process;
    logic [63:0] match_word;
    logic [63:0] requested_length;
    logic [63:0] manipulated_length;
    logic [63:0] offset_remote;
    logic [63:0] start_address;
    logic [63:0] user_tag;
    logic [63:0] header_word;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // commands from sequencer to pointer control
  typedef struct packed {
    logic post;
    logic get;
  } ctrl_cmd_t;

  // ring status seen by the sequencer
  typedef struct packed {
    logic empty;
    logic dropped;
  } ctrl_stat_t;

endpackage

FILE: hdl/overwriting_event_ring_queue_unit.sv
// Top level of the overwriting event ring queue: sequencer, pointer control, slot RAM, output register.
//
//  channel | ports                         | direction | handshake
//  --------+-------------------------------+-----------+-----------------------
//  in      | in_func, in_* event record    | input     | in_valid / in_ready
//  out     | out_status, out_* record      | output    | out_valid / out_ready
//  cfg     | cfg_wr_data (ring size)       | input     | cfg_wr_en, no wait
//
// A post writes the record to the slot RAM at the accept edge and loads the
// status-only result into the output register. A get first waits in the
// read state for the registered read data of the slot RAM.
// Reset (rst_n low, synchronous) clears pointers, laps, overflow mark, the
// sequencer and out_valid; ring size returns to 1024. Slot contents are not
// cleared. in_ready is low while a get waits on the RAM and while a result
// is held in the output register that is not taken in the same cycle.
module overwriting_event_ring_queue_unit #(
  parameter int MAX_SLOTS = oerq_pkg::MAX_SLOTS_DEF,
  parameter int LAP_WIDTH = oerq_pkg::LAP_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [oerq_pkg::CFG_W-1:0] cfg_wr_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [16:0]                in_attributes,
  input  logic [15:0]                in_portal_index,
  input  logic [63:0]                in_user_job_ids,
  input  logic [63:0]                in_peer_process,
  input  logic [63:0]                in_match_word,
  input  logic [63:0]                in_requested_length,
  input  logic [63:0]                in_manipulated_length,
  input  logic [63:0]                in_offset_remote,
  input  logic [63:0]                in_start_address,
  input  logic [63:0]                in_user_tag,
  input  logic [63:0]                in_header_word,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [16:0]                out_attributes,
  output logic [15:0]                out_portal_index,
  output logic [63:0]                out_user_job_ids,
  output logic [63:0]                out_peer_process,
  output logic [63:0]                out_match_word,
  output logic [63:0]                out_requested_length,
  output logic [63:0]                out_manipulated_length,
  output logic [63:0]                out_offset_remote,
  output logic [63:0]                out_start_address,
  output logic [63:0]                out_user_tag,
  output logic [63:0]                out_header_word
);

  localparam int PTR_W = $clog2(MAX_SLOTS);

  oerq_pkg::seq_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  oerq_pkg::status_t    out_status_r, out_status_nxt;
  oerq_pkg::record_t    out_rec_r, out_rec_nxt;
  oerq_pkg::status_t    pend_status_r, pend_status_nxt;  // status of the get in flight

  oerq_pkg::ctrl_cmd_t  cmd;
  oerq_pkg::ctrl_stat_t stat;
  oerq_pkg::record_t    in_rec, rd_rec;
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [oerq_pkg::REC_W-1:0] rd_data;
  logic                 in_xfer, out_xfer, is_get;

  assign in_rec.attributes         = in_attributes;
  assign in_rec.portal_index       = in_portal_index;
  assign in_rec.user_job_ids       = in_user_job_ids;
  assign in_rec.peer_process       = in_peer_process;
  assign in_rec.match_word         = in_match_word;
  assign in_rec.requested_length   = in_requested_length;
  assign in_rec.manipulated_length = in_manipulated_length;
  assign in_rec.offset_remote      = in_offset_remote;
  assign in_rec.start_address      = in_start_address;
  assign in_rec.user_tag           = in_user_tag;
  assign in_rec.header_word        = in_header_word;

  // one item at a time; the output register frees up in the same cycle it drains
  assign in_ready = (state_r == oerq_pkg::SEQ_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;
  assign is_get   = (in_func == oerq_pkg::FUNC_GET);

  assign cmd.post = in_xfer && !is_get;
  assign cmd.get  = in_xfer && is_get;

  assign rd_rec = oerq_pkg::record_t'(rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oerq_pkg::SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_rec_r     <= out_rec_nxt;
    pend_status_r <= pend_status_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_xfer;
    out_status_nxt  = out_status_r;
    out_rec_nxt     = out_rec_r;
    pend_status_nxt = pend_status_r;
    unique case (state_r)
      oerq_pkg::SEQ_IDLE: begin
        if (cmd.post) begin
          // posts always report ok with an all-zero record
          out_valid_nxt  = 1'b1;
          out_status_nxt = oerq_pkg::STATUS_OK;
          out_rec_nxt    = '0;
        end else if (cmd.get) begin
          priority if (stat.empty) begin
            pend_status_nxt = oerq_pkg::STATUS_EMPTY;
          end else if (stat.dropped) begin
            pend_status_nxt = oerq_pkg::STATUS_DROPPED;
          end else begin
            pend_status_nxt = oerq_pkg::STATUS_OK;
          end
          state_nxt = oerq_pkg::SEQ_READ;
        end
      end
      oerq_pkg::SEQ_READ: begin
        // RAM data for the slot read at the accept edge is here now
        out_valid_nxt  = 1'b1;
        out_status_nxt = pend_status_r;
        out_rec_nxt    = (pend_status_r == oerq_pkg::STATUS_EMPTY) ? '0 : rd_rec;
        state_nxt      = oerq_pkg::SEQ_IDLE;
      end
      default: begin
        state_nxt = oerq_pkg::SEQ_IDLE;
      end
    endcase
  end

  oerq_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .LAP_WIDTH (LAP_WIDTH),
    .PTR_W     (PTR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .wr_ptr      (wr_ptr),
    .rd_ptr      (rd_ptr),
    .stat        (stat)
  );

  // slot store; only one item is in flight, so a read and a write of the
  // same slot never share a cycle
  oerq_ram #(
    .WIDTH  (oerq_pkg::REC_W),
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (PTR_W)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.post),
    .waddr (wr_ptr),
    .wdata (in_rec),
    .re    (cmd.get && !stat.empty),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_attributes         = out_rec_r.attributes;
  assign out_portal_index       = out_rec_r.portal_index;
  assign out_user_job_ids       = out_rec_r.user_job_ids;
  assign out_peer_process       = out_rec_r.peer_process;
  assign out_match_word         = out_rec_r.match_word;
  assign out_requested_length   = out_rec_r.requested_length;
  assign out_manipulated_length = out_rec_r.manipulated_length;
  assign out_offset_remote      = out_rec_r.offset_remote;
  assign out_start_address      = out_rec_r.start_address;
  assign out_user_tag           = out_rec_r.user_tag;
  assign out_header_word        = out_rec_r.header_word;

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oerq_pkg::SEQ_READ) |=> (state_r == oerq_pkg::SEQ_IDLE && out_valid))
    else $error("get result not delivered after RAM read");

  a_get_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.get |=> (state_r == oerq_pkg::SEQ_READ && !out_valid))
    else $error("get did not wait on RAM read");

  a_post_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |=> (out_valid && out_status == oerq_pkg::STATUS_OK))
    else $error("post result missing or not ok");

endmodule

FILE: hdl/oerq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oerq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/oerq_ctrl.sv
// Ring pointers, lap counters, overflow mark and ring size register.
module oerq_ctrl #(
  parameter int MAX_SLOTS = oerq_pkg::MAX_SLOTS_DEF,
  parameter int LAP_WIDTH = oerq_pkg::LAP_W_DEF,
  parameter int PTR_W     = $clog2(MAX_SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [oerq_pkg::CFG_W-1:0] cfg_wr_data,
  input  oerq_pkg::ctrl_cmd_t        cmd,
  output logic [PTR_W-1:0]           wr_ptr,
  output logic [PTR_W-1:0]           rd_ptr,
  output oerq_pkg::ctrl_stat_t       stat
);

  localparam int CMP_W = (PTR_W + 1 > oerq_pkg::CFG_W) ? PTR_W + 1 : oerq_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SLOTS);
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

  logic [oerq_pkg::CFG_W-1:0] size_r;
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [LAP_WIDTH-1:0]       wr_lap_r, wr_lap_nxt;
  logic [LAP_WIDTH-1:0]       rd_lap_r, rd_lap_nxt;
  logic                       lost_r, lost_nxt;

  logic [CMP_W-1:0] size_ext, eff_size, wr_inc, rd_inc;
  logic             empty;

  // clamp size into 1..MAX_SLOTS
  always_comb begin
    size_ext = CMP_W'(size_r);
    priority if (size_ext == '0) begin
      eff_size = ONE_C;
    end else if (size_ext > MAX_C) begin
      eff_size = MAX_C;
    end else begin
      eff_size = size_ext;
    end
  end

  assign wr_inc = CMP_W'(wr_ptr_r) + ONE_C;
  assign rd_inc = CMP_W'(rd_ptr_r) + ONE_C;
  assign empty  = (wr_ptr_r == rd_ptr_r) && (wr_lap_r == rd_lap_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    wr_lap_nxt = wr_lap_r;
    rd_ptr_nxt = rd_ptr_r;
    rd_lap_nxt = rd_lap_r;
    lost_nxt   = lost_r;
    if (cmd.post) begin
      // writer a lap ahead and at/past reader: overwriting unread slot
      if ((wr_lap_r != rd_lap_r) && (wr_ptr_r >= rd_ptr_r)) begin
        lost_nxt = 1'b1;
      end
      if (wr_inc >= eff_size) begin
        wr_ptr_nxt = '0;
        wr_lap_nxt = wr_lap_r + LAP_WIDTH'(1);
      end else begin
        wr_ptr_nxt = wr_inc[PTR_W-1:0];
      end
    end else if (cmd.get && !empty) begin
      lost_nxt = 1'b0;
      if (rd_inc >= eff_size) begin
        rd_ptr_nxt = '0;
        rd_lap_nxt = rd_lap_r + LAP_WIDTH'(1);
      end else begin
        rd_ptr_nxt = rd_inc[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= oerq_pkg::RING_SIZE_RST;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      wr_lap_r <= '0;
      rd_lap_r <= '0;
      lost_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_lap_r <= wr_lap_nxt;
      rd_lap_r <= rd_lap_nxt;
      lost_r   <= lost_nxt;
    end
  end

  assign wr_ptr       = wr_ptr_r;
  assign rd_ptr       = rd_ptr_r;
  assign stat.empty   = empty;
  assign stat.dropped = lost_r;

  // empty get must not move the reader
  a_empty_get_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.get && !cmd.post && empty) |=> ($stable(rd_ptr_r) && $stable(rd_lap_r)))
    else $error("reader moved on empty get");

  // a non-empty get always clears the overflow mark
  a_get_clears_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.get && !cmd.post && !empty) |=> !lost_r)
    else $error("overflow mark survived a get");

  // overflow mark only rises on a post
  a_lost_on_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lost_r) |-> $past(cmd.post))
    else $error("overflow mark set without post");

endmodule

FILE: sim/overwriting_event_ring_queue_unit_tb.sv
// Self-checking testbench for the overwriting event ring queue: directed table, then random phases.
`timescale 1ns / 100ps

module overwriting_event_ring_queue_unit_tb;
  import oerq_pkg::*;

  localparam int          SLOTS       = MAX_SLOTS_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          MAX_REPORTS = 30;
  localparam int          PHASE_COUNT = 12;
  localparam int          VEC_COUNT   = 22;

  // Record patterns for the directed table. PAT_RAND rows get fresh random content
  // and are checked against the ring predictor unless the row is typed.
  typedef enum logic [1:0] {
    PAT_ZERO = 2'd0,
    PAT_ONES = 2'd1,
    PAT_ALT  = 2'd2,
    PAT_RAND = 2'd3
  } pattern_t;

  // Receiver back-pressure styles.
  typedef enum logic [1:0] {
    SINK_OPEN    = 2'd0,
    SINK_COIN    = 2'd1,
    SINK_SPARSE  = 2'd2,
    SINK_CHOKED  = 2'd3
  } sink_mode_t;

  // One result transfer as the block should present it.
  typedef struct packed {
    status_t status;
    record_t rec;
  } result_t;

  // One directed row. resize: wait for the queue to go idle, then write size first.
  // typed: the expected result is want_status / want_pat, not the predictor's.
  typedef struct packed {
    bit          resize;
    logic [10:0] size;
    func_t       func;
    pattern_t    pat;
    bit          typed;
    status_t     want_status;
    pattern_t    want_pat;
  } vector_t;

  // Directed part.
  // Rows 0-7 run at the reset size: get from an empty ring, posts of the field
  // extremes and an alternating pattern, reads back in order, empty again.
  // Rows 8-14 shrink the ring to 2 while both pointers sit at slot 3, so the
  // first post and the first get still touch slot 3 before wrapping.
  // Rows 15-21 overrun the reader (the third post sets the overflow mark):
  // the next get reports dropped, and since the reader is a lap behind it
  // keeps returning slots, one of them twice, until pointers and laps match.
  vector_t directed_vec [VEC_COUNT] = '{
    '{1'b0, 11'd0, FUNC_GET,  PAT_ZERO, 1'b1, STATUS_EMPTY, PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_ONES, 1'b1, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_ZERO, 1'b1, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_ALT,  1'b1, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_ZERO, 1'b1, STATUS_OK,    PAT_ONES},
    '{1'b0, 11'd0, FUNC_GET,  PAT_ONES, 1'b1, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_ONES, 1'b1, STATUS_EMPTY, PAT_ZERO},
    '{1'b1, 11'd2, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b1, STATUS_EMPTY, PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_POST, PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b0, STATUS_OK,    PAT_ZERO},
    '{1'b0, 11'd0, FUNC_GET,  PAT_RAND, 1'b1, STATUS_EMPTY, PAT_ZERO}
  };

  // Random phases: ring size written, item count, share of posts in percent.
  // The first phase writes all ones (acts as the full ring) and leans hard on
  // posts so the writer laps the reader at the maximum size; it also leaves
  // every slot written. Size 0 acts as a single slot.
  int unsigned phase_size  [PHASE_COUNT] = '{2047, 0, 1, 3, 5, 7, 16, 2, 4, 11, 1024, 1};
  int unsigned phase_items [PHASE_COUNT] = '{1100, 70, 60, 80, 70, 80, 80, 60, 70, 70, 60, 40};
  int unsigned phase_posts [PHASE_COUNT] = '{98, 60, 50, 65, 40, 70, 55, 60, 75, 50, 50, 50};

  // DUT connections; every input starts at a known value.
  logic        clk;
  logic        rst_n                  = 1'b0;
  logic        cfg_wr_en              = 1'b0;
  logic [10:0] cfg_wr_data            = '0;
  logic        in_valid               = 1'b0;
  logic        in_ready;
  func_t       in_func                = FUNC_POST;
  logic [16:0] in_attributes          = '0;
  logic [15:0] in_portal_index        = '0;
  logic [63:0] in_user_job_ids        = '0;
  logic [63:0] in_peer_process        = '0;
  logic [63:0] in_match_word          = '0;
  logic [63:0] in_requested_length    = '0;
  logic [63:0] in_manipulated_length  = '0;
  logic [63:0] in_offset_remote       = '0;
  logic [63:0] in_start_address       = '0;
  logic [63:0] in_user_tag            = '0;
  logic [63:0] in_header_word         = '0;
  logic        out_valid;
  logic        out_ready              = 1'b0;
  logic [1:0]  out_status;
  logic [16:0] out_attributes;
  logic [15:0] out_portal_index;
  logic [63:0] out_user_job_ids;
  logic [63:0] out_peer_process;
  logic [63:0] out_match_word;
  logic [63:0] out_requested_length;
  logic [63:0] out_manipulated_length;
  logic [63:0] out_offset_remote;
  logic [63:0] out_start_address;
  logic [63:0] out_user_tag;
  logic [63:0] out_header_word;

  // Ring predictor state: slot contents, which slots hold a record, pointers,
  // lap counts, overflow mark and the ring size register.
  record_t     slot_rec     [SLOTS];
  bit          slot_written [SLOTS];
  int unsigned wr_ptr       = 0;
  int unsigned rd_ptr       = 0;
  logic [31:0] wr_lap       = '0;
  logic [31:0] rd_lap       = '0;
  bit          overrun      = 1'b0;
  logic [10:0] ring_size    = RING_SIZE_RST;

  result_t     awaited_results [$];
  result_t     due_result;
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  sink_mode_t  sink_mode;

  overwriting_event_ring_queue_unit i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_func                (in_func),
    .in_attributes          (in_attributes),
    .in_portal_index        (in_portal_index),
    .in_user_job_ids        (in_user_job_ids),
    .in_peer_process        (in_peer_process),
    .in_match_word          (in_match_word),
    .in_requested_length    (in_requested_length),
    .in_manipulated_length  (in_manipulated_length),
    .in_offset_remote       (in_offset_remote),
    .in_start_address       (in_start_address),
    .in_user_tag            (in_user_tag),
    .in_header_word         (in_header_word),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_attributes         (out_attributes),
    .out_portal_index       (out_portal_index),
    .out_user_job_ids       (out_user_job_ids),
    .out_peer_process       (out_peer_process),
    .out_match_word         (out_match_word),
    .out_requested_length   (out_requested_length),
    .out_manipulated_length (out_manipulated_length),
    .out_offset_remote      (out_offset_remote),
    .out_start_address      (out_start_address),
    .out_user_tag           (out_user_tag),
    .out_header_word        (out_header_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Slots in use: 0 behaves as 1, anything past the ring depth as the full ring.
  function automatic int unsigned ring_span();
    if (ring_size == '0) return 1;
    if (ring_size > 11'(SLOTS)) return SLOTS;
    return ring_size;
  endfunction

  function automatic bit ring_empty();
    return wr_ptr == rd_ptr && wr_lap == rd_lap;
  endfunction

  // Applies one accepted item to the predicted ring and returns its result.
  // Both pointers use their current value even when it sits past a ring that
  // was just shrunk, and only then wrap to zero with a lap bump.
  function automatic result_t apply_to_ring(input func_t func, input record_t rec);
    result_t res;
    res = '0;
    if (func == FUNC_POST) begin
      if (wr_lap != rd_lap && wr_ptr >= rd_ptr) overrun = 1'b1;
      slot_rec[wr_ptr]     = rec;
      slot_written[wr_ptr] = 1'b1;
      if (wr_ptr + 1 >= ring_span()) begin
        wr_ptr = 0;
        wr_lap = wr_lap + 1;
      end else begin
        wr_ptr = wr_ptr + 1;
      end
    end else if (ring_empty()) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.status = overrun ? STATUS_DROPPED : STATUS_OK;
      overrun    = 1'b0;
      res.rec    = slot_rec[rd_ptr];
      if (rd_ptr + 1 >= ring_span()) begin
        rd_ptr = 0;
        rd_lap = rd_lap + 1;
      end else begin
        rd_ptr = rd_ptr + 1;
      end
    end
    return res;
  endfunction

  function automatic record_t random_record();
    record_t     rec;
    logic [31:0] word;
    word                   = $urandom;
    rec.attributes         = word[16:0];
    word                   = $urandom;
    rec.portal_index       = word[15:0];
    rec.user_job_ids       = {$urandom, $urandom};
    rec.peer_process       = {$urandom, $urandom};
    rec.match_word         = {$urandom, $urandom};
    rec.requested_length   = {$urandom, $urandom};
    rec.manipulated_length = {$urandom, $urandom};
    rec.offset_remote      = {$urandom, $urandom};
    rec.start_address      = {$urandom, $urandom};
    rec.user_tag           = {$urandom, $urandom};
    rec.header_word        = {$urandom, $urandom};
    return rec;
  endfunction

  function automatic record_t pattern_record(input pattern_t pat);
    record_t rec;
    case (pat)
      PAT_ZERO: rec = '0;
      PAT_ONES: rec = '1;
      PAT_ALT: begin
        for (int i = 0; i < REC_W; i++) rec[i] = i[0] ^ i[3];
      end
      default: rec = random_record();
    endcase
    return rec;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Drop valid and hold until every awaited result has been taken, then
  // idle on as a margin for the get read latency.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Ring size is only written with the queue idle.
  task automatic write_ring_size(input logic [10:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ring_size    = value;
  endtask

  // Presents one item, waits for its transfer, records the expected result,
  // then idles the sender according to the burst/gap pattern.
  task automatic send_event(input func_t func, input record_t rec, input bit typed,
                            input result_t typed_res);
    result_t res;
    in_valid              <= 1'b1;
    in_func               <= func;
    in_attributes         <= rec.attributes;
    in_portal_index       <= rec.portal_index;
    in_user_job_ids       <= rec.user_job_ids;
    in_peer_process       <= rec.peer_process;
    in_match_word         <= rec.match_word;
    in_requested_length   <= rec.requested_length;
    in_manipulated_length <= rec.manipulated_length;
    in_offset_remote      <= rec.offset_remote;
    in_start_address      <= rec.start_address;
    in_user_tag           <= rec.user_tag;
    in_header_word        <= rec.header_word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    res = apply_to_ring(func, rec);
    awaited_results.push_back(typed ? typed_res : res);
    if ($urandom_range(0, 299) == 0) begin
      // sender holds off until the result side has caught up completely
      wait_drained();
    end else if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  task automatic run_random(input logic [10:0] size, input int unsigned items,
                            input int unsigned post_pct);
    func_t func;
    write_ring_size(size);
    repeat (items) begin
      func = ($urandom_range(0, 99) < post_pct) ? FUNC_POST : FUNC_GET;
      // never let a get land on a slot that holds no record yet
      if (func == FUNC_GET && !ring_empty() && !slot_written[rd_ptr]) func = FUNC_POST;
      send_event(func, random_record(), 1'b0, '0);
    end
  endtask

  // Receiver: ready follows a style that is picked anew at random,
  // from always open down to long stalls.
  initial begin
    forever begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(40, 300)) begin
        @(posedge clk);
        case (sink_mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
          SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= ($urandom_range(0, 24) == 0);
        endcase
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $error("result transfer with no result awaited, status %0d", out_status);
      end else begin
        due_result = awaited_results.pop_front();
        check_field("status", due_result.status, out_status);
        check_field("attributes", due_result.rec.attributes, out_attributes);
        check_field("portal_index", due_result.rec.portal_index, out_portal_index);
        check_field("user_job_ids", due_result.rec.user_job_ids, out_user_job_ids);
        check_field("peer_process", due_result.rec.peer_process, out_peer_process);
        check_field("match_word", due_result.rec.match_word, out_match_word);
        check_field("requested_length", due_result.rec.requested_length,
                    out_requested_length);
        check_field("manipulated_length", due_result.rec.manipulated_length,
                    out_manipulated_length);
        check_field("offset_remote", due_result.rec.offset_remote, out_offset_remote);
        check_field("start_address", due_result.rec.start_address, out_start_address);
        check_field("user_tag", due_result.rec.user_tag, out_user_tag);
        check_field("header_word", due_result.rec.header_word, out_header_word);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("overwriting_event_ring_queue_unit_tb failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin
    result_t typed_res;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_vec[i]) begin
      if (directed_vec[i].resize) write_ring_size(directed_vec[i].size);
      typed_res.status = directed_vec[i].want_status;
      typed_res.rec    = pattern_record(directed_vec[i].want_pat);
      send_event(directed_vec[i].func, pattern_record(directed_vec[i].pat),
                 directed_vec[i].typed, typed_res);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // every third phase runs the sender with no burst gaps
      gaps_on = (p % 3 != 1);
      run_random(11'(phase_size[p]), phase_items[p], phase_posts[p]);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("overwriting_event_ring_queue_unit_tb passed");
    end else begin
      $display("overwriting_event_ring_queue_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/oerq_pkg.sv
hdl/oerq_ram.sv
hdl/oerq_ctrl.sv
hdl/overwriting_event_ring_queue_unit.sv
sim/overwriting_event_ring_queue_unit_tb.sv
